// ----- src/biq_pkg.sv -----
// ----------------------------------------------------------------------------
// biq_pkg
// Shared sizes, register codes and types of the biquad IIR filter.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 32;
  localparam int COEF_FRAC_BITS = 28;
  localparam int CFG_IDX_BITS   = 3;

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;
  localparam int RND_BITS  = ACC_BITS - COEF_FRAC_BITS;

  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } biq_reg_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } biq_coef_t;

  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } biq_hist_t;

endpackage

// ----- src/biq_ifs.sv -----
// ----------------------------------------------------------------------------
// biq_in_if / biq_out_if
// Valid/ready sample channels of the biquad IIR filter.
// ----------------------------------------------------------------------------
interface biq_in_if;
  logic                 valid;
  logic                 ready;
  biq_pkg::sample_t     sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if;
  logic                 valid;
  logic                 ready;
  biq_pkg::sample_t     sample_out;
  logic                 clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ----- src/biq_coef_regs.sv -----
// ----------------------------------------------------------------------------
// biq_coef_regs
// Coefficient register bank, written through the configuration port.
// ----------------------------------------------------------------------------
module biq_coef_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [biq_pkg::COEF_BITS-1:0]     cfg_data_i,
  output biq_pkg::biq_coef_t                coef_o
);
  import biq_pkg::*;

  biq_coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= COEF_ONE;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else if (cfg_we_i) begin
      unique case (biq_reg_e'(cfg_idx_i))
        REG_B0:  coef_q.b0 <= cfg_data_i;
        REG_B1:  coef_q.b1 <= cfg_data_i;
        REG_B2:  coef_q.b2 <= cfg_data_i;
        REG_A1:  coef_q.a1 <= cfg_data_i;
        REG_A2:  coef_q.a2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

// ----- src/biq_mac.sv -----
// ----------------------------------------------------------------------------
// biq_mac
// Five-tap multiply-accumulate, round half up and saturation of one sample.
// ----------------------------------------------------------------------------
module biq_mac (
  input  biq_pkg::sample_t   x_i,
  input  biq_pkg::biq_hist_t hist_i,
  input  biq_pkg::biq_coef_t coef_i,
  output biq_pkg::sample_t   y_o,
  output logic               clip_o
);
  import biq_pkg::*;

  logic signed [PROD_BITS-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  acc_rnd;
  logic        [RND_BITS-1:0]  rnd;
  logic        [RND_BITS-SAMPLE_BITS:0] rnd_hi;
  logic                        ovf;

  assign p_b0 = PROD_BITS'(coef_i.b0) * PROD_BITS'(x_i);
  assign p_b1 = PROD_BITS'(coef_i.b1) * PROD_BITS'(hist_i.x1);
  assign p_b2 = PROD_BITS'(coef_i.b2) * PROD_BITS'(hist_i.x2);
  assign p_a1 = PROD_BITS'(coef_i.a1) * PROD_BITS'(hist_i.y1);
  assign p_a2 = PROD_BITS'(coef_i.a2) * PROD_BITS'(hist_i.y2);

  assign acc = ACC_BITS'(p_b0) + ACC_BITS'(p_b1) + ACC_BITS'(p_b2)
             - ACC_BITS'(p_a1) - ACC_BITS'(p_a2);

  assign acc_rnd = acc + (ACC_BITS'(1) << (COEF_FRAC_BITS - 1));
  assign rnd     = acc_rnd[ACC_BITS-1:COEF_FRAC_BITS];
  assign rnd_hi  = rnd[RND_BITS-1:SAMPLE_BITS-1];
  assign ovf     = !((&rnd_hi) || !(|rnd_hi));

  always_comb begin
    clip_o = ovf;
    if (!ovf) begin
      y_o = rnd[SAMPLE_BITS-1:0];
    end else if (rnd[RND_BITS-1]) begin
      y_o = SAMPLE_MIN;
    end else begin
      y_o = SAMPLE_MAX;
    end
  end

endmodule

// ----- src/biquad_iir_filter.sv -----
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Direct-form-I biquad on Q1.23 samples with Q4.28 coefficients.
//
//   channel   dir  handshake         payload
//   in_if     in   valid / ready     sample_in[23:0]
//   out_if    out  valid / ready     sample_out[23:0], clipped
//   cfg       in   cfg_we_i          cfg_idx_i[2:0], cfg_data_i[31:0]
//
// One sample per cycle sustained while the output is not stalled; a sample passes
// through the input register and then the output register. The five multipliers,
// the adder and the saturation sit in one stage between the input register and
// the output register; the history register, loaded with it, closes the output
// feedback loop. Reset clears the history and loads unity gain.
// A stalled output holds one result while the input register takes one more.
// ----------------------------------------------------------------------------
module biquad_iir_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  biq_in_if.sink                            in_if,
  biq_out_if.source                         out_if,
  input  logic                              cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [biq_pkg::COEF_BITS-1:0]     cfg_data_i
);
  import biq_pkg::*;

  biq_coef_t coef;
  biq_hist_t hist_q;
  sample_t   x_q;
  logic      x_vld_q;
  sample_t   y_d;
  logic      clip_d;
  sample_t   y_q;
  logic      clip_q;
  logic      out_vld_q;
  logic      adv;

  biq_coef_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef)
  );

  biq_mac u_mac (
    .x_i    (x_q),
    .hist_i (hist_q),
    .coef_i (coef),
    .y_o    (y_d),
    .clip_o (clip_d)
  );

  assign adv         = x_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !x_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      hist_q    <= '0;
    end else begin
      if (in_if.ready) begin
        x_vld_q <= in_if.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        hist_q.x1 <= x_q;
        hist_q.x2 <= hist_q.x1;
        hist_q.y1 <= y_d;
        hist_q.y2 <= hist_q.y1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      x_q <= in_if.sample_in;
    end
    if (adv) begin
      y_q    <= y_d;
      clip_q <= clip_d;
    end
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.sample_out = y_q;
  assign out_if.clipped    = clip_q;

endmodule

// ----- src/biq_checker.sv -----
// ----------------------------------------------------------------------------
// biq_checker
// Port-level checks of the biquad IIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module biq_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input biq_pkg::sample_t sample_out_i,
  input logic             clipped_i
);
  import biq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sample_out_i) && $stable(clipped_i))
    else $error("stalled output changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("output appeared without input transfer");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clipped_i |-> sample_out_i == SAMPLE_MAX || sample_out_i == SAMPLE_MIN)
    else $error("clip flag without saturated value");

endmodule

bind biquad_iir_filter biq_checker u_biq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .sample_out_i (out_if.sample_out),
  .clipped_i    (out_if.clipped)
);
